FILE: src/itc_pkg.sv
`default_nettype none
package itc_pkg;

  localparam int COUNT_BITS_DEF = 16;

  // command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic PORT_DATA = 1'b0;
  localparam logic PORT_CTRL = 1'b1;

  // control word fields
  localparam logic [1:0] SEL_COUNTER0   = 2'b00;
  localparam logic [1:0] ACCESS_LATCH   = 2'b00;
  localparam logic [1:0] ACCESS_LSB_MSB = 2'b11;
  localparam logic [1:0] MODE_RATE      = 2'b10;

  typedef struct packed {
    logic [1:0] command;
    logic       port;
    logic [7:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
    logic       out_level;
  } out_item_t;

endpackage
`default_nettype wire

FILE: src/itc_core.sv
`default_nettype none
module itc_core import itc_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      item_fire,
  input  wire in_item_t  item,
  output out_item_t      result
);

  logic [2:0]            mode_r, mode_nxt;
  logic [COUNT_BITS-1:0] reload_r, reload_nxt;
  logic [COUNT_BITS-1:0] cur_r, cur_nxt;
  logic [COUNT_BITS-1:0] latched_r, latched_nxt;
  logic [7:0]            staged_r, staged_nxt;
  logic                  latch_held_r, latch_held_nxt;
  logic                  whn_r, whn_nxt;
  logic                  rhn_r, rhn_nxt;
  logic                  ce_r, ce_nxt;
  logic                  pin_r, pin_nxt;
  logic                  lp_r, lp_nxt;

  logic                  rate;
  logic [31:0]           wr_word;
  logic [31:0]           rd_word;
  logic [COUNT_BITS-1:0] dec;
  logic [7:0]            rd_byte;

  assign rate = (mode_r[1:0] == MODE_RATE);
  assign dec  = cur_r - COUNT_BITS'(1);

  always_comb begin
    mode_nxt       = mode_r;
    reload_nxt     = reload_r;
    cur_nxt        = cur_r;
    latched_nxt    = latched_r;
    staged_nxt     = staged_r;
    latch_held_nxt = latch_held_r;
    whn_nxt        = whn_r;
    rhn_nxt        = rhn_r;
    ce_nxt         = ce_r;
    pin_nxt        = pin_r;
    lp_nxt         = lp_r;
    rd_byte        = 8'h00;
    wr_word        = {16'h0000, item.write_data, staged_r};
    rd_word        = '0;
    rd_word[COUNT_BITS-1:0] = latch_held_r ? latched_r : cur_r;

    unique case (item.command)
      CMD_WRITE: begin
        if (item.port == PORT_CTRL) begin
          if (item.write_data[7:6] == SEL_COUNTER0) begin
            if (item.write_data[5:4] == ACCESS_LATCH) begin
              if (!latch_held_r) begin
                latched_nxt    = cur_r;
                latch_held_nxt = 1'b1;
              end
            end else if (item.write_data[5:4] == ACCESS_LSB_MSB) begin
              mode_nxt       = item.write_data[3:1];
              whn_nxt        = 1'b0;
              rhn_nxt        = 1'b0;
              latch_held_nxt = 1'b0;
              ce_nxt         = 1'b0;
              lp_nxt         = 1'b0;
              pin_nxt        = (item.write_data[2:1] == MODE_RATE);
            end
          end
        end else if (!whn_r) begin
          staged_nxt = item.write_data;
          whn_nxt    = 1'b1;
          if (!rate) ce_nxt = 1'b0;
        end else begin
          whn_nxt    = 1'b0;
          reload_nxt = wr_word[COUNT_BITS-1:0];
          if (rate) begin
            if (!ce_r) begin
              ce_nxt = 1'b1;
              lp_nxt = 1'b1;
            end
          end else begin
            pin_nxt = 1'b0;
            ce_nxt  = 1'b1;
            lp_nxt  = 1'b1;
          end
        end
      end
      CMD_READ: begin
        if (item.port == PORT_DATA) begin
          if (!rhn_r) begin
            rd_byte = rd_word[7:0];
            rhn_nxt = 1'b1;
          end else begin
            rd_byte        = rd_word[15:8];
            rhn_nxt        = 1'b0;
            latch_held_nxt = 1'b0;
          end
        end
      end
      CMD_TICK: begin
        if (ce_r) begin
          if (lp_r) begin
            cur_nxt = reload_r;
            lp_nxt  = 1'b0;
          end else if (rate) begin
            if (cur_r == COUNT_BITS'(1)) begin
              cur_nxt = reload_r;
              pin_nxt = 1'b1;
            end else begin
              cur_nxt = dec;
              if (dec == COUNT_BITS'(1)) pin_nxt = 1'b0;
            end
          end else begin
            cur_nxt = dec;
            if (dec == '0) pin_nxt = 1'b1;
          end
        end
      end
      default: begin
        // unused command code: no effect
      end
    endcase
  end

  assign result.read_data = rd_byte;
  assign result.irq       = (item.command == CMD_TICK) && !pin_r && pin_nxt;
  assign result.out_level = pin_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= '0;
      reload_r     <= '0;
      cur_r        <= '0;
      latched_r    <= '0;
      staged_r     <= '0;
      latch_held_r <= 1'b0;
      whn_r        <= 1'b0;
      rhn_r        <= 1'b0;
      ce_r         <= 1'b0;
      pin_r        <= 1'b0;
      lp_r         <= 1'b0;
    end else if (item_fire) begin
      mode_r       <= mode_nxt;
      reload_r     <= reload_nxt;
      cur_r        <= cur_nxt;
      latched_r    <= latched_nxt;
      staged_r     <= staged_nxt;
      latch_held_r <= latch_held_nxt;
      whn_r        <= whn_nxt;
      rhn_r        <= rhn_nxt;
      ce_r         <= ce_nxt;
      pin_r        <= pin_nxt;
      lp_r         <= lp_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/interval_timer_counter.sv
// Path: an item enters the input register, then the result register, where
//   out_valid rises; a full result register that is not drained holds it back.
// Throughput: one item per cycle unless out_ready stalls; the counter state updates
//   in a single pass as an item moves from the input to the result register.
// Reset: rst_n is synchronous, active low; clears both pipeline valids and all
//   counter state (mode 0, counts zero, output pin low, counting stopped).
`default_nettype none
module interval_timer_counter import itc_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  // Input stage: holds one item until the result register has room.
  logic      s1_vld_r;
  in_item_t  s1_item_r;
  logic      s1_adv;

  // Result stage
  logic      out_vld_r;
  out_item_t out_item_r;
  out_item_t core_result;

  // The input stage moves on whenever the result register is empty or drains
  // this cycle, so a new item can enter every cycle under no backpressure.
  assign s1_adv   = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;

  // Counter state commits only when the item moves to the result register,
  // so each item updates the state exactly once.
  itc_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_fire(s1_adv),
    .item     (s1_item_r),
    .result   (core_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || out_ready) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item_r <= core_result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

FILE: bench/itc_checker.sv
`timescale 1ns / 100ps
module itc_checker import itc_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  output int        fail_count,
  output int        results_due
);

  typedef logic [COUNT_BITS-1:0] count_t;

  // shadow copy of counter 0
  logic [2:0] mode_sel;
  count_t     reload_val;
  count_t     count_val;
  count_t     latch_val;
  logic       latch_held;
  logic       wr_msb_next;
  logic       rd_msb_next;
  logic       counting;
  logic       out_pin;
  logic       load_next;
  logic [7:0] lsb_hold;

  out_item_t  timer_results_q[$];

  initial fail_count = 0;

  function automatic logic rate_mode(input logic [2:0] m);
    return m[1:0] == MODE_RATE;
  endfunction

  task automatic clear_timer();
    mode_sel    = '0;
    reload_val  = '0;
    count_val   = '0;
    latch_val   = '0;
    latch_held  = 1'b0;
    wr_msb_next = 1'b0;
    rd_msb_next = 1'b0;
    counting    = 1'b0;
    out_pin     = 1'b0;
    load_next   = 1'b0;
    lsb_hold    = '0;
  endtask

  task automatic control_word(input logic [7:0] w);
    if (w[7:6] != SEL_COUNTER0) return;
    if (w[5:4] == ACCESS_LATCH) begin
      if (!latch_held) begin
        latch_val  = count_val;
        latch_held = 1'b1;
      end
      return;
    end
    if (w[5:4] != ACCESS_LSB_MSB) return;
    mode_sel    = w[3:1];
    wr_msb_next = 1'b0;
    rd_msb_next = 1'b0;
    latch_held  = 1'b0;
    counting    = 1'b0;
    load_next   = 1'b0;
    out_pin     = rate_mode(w[3:1]);
  endtask

  task automatic count_byte(input logic [7:0] b);
    logic [15:0] full;
    if (!wr_msb_next) begin
      lsb_hold    = b;
      wr_msb_next = 1'b1;
      if (!rate_mode(mode_sel)) counting = 1'b0;
      return;
    end
    wr_msb_next = 1'b0;
    full        = {b, lsb_hold};
    reload_val  = count_t'(full);
    if (rate_mode(mode_sel)) begin
      // periodic mode: new value waits for the next reload
      if (!counting) begin
        counting  = 1'b1;
        load_next = 1'b1;
      end
    end else begin
      out_pin   = 1'b0;
      counting  = 1'b1;
      load_next = 1'b1;
    end
  endtask

  task automatic read_byte(output logic [7:0] r);
    logic [31:0] v;
    v = 32'(latch_held ? latch_val : count_val);
    if (!rd_msb_next) begin
      r           = v[7:0];
      rd_msb_next = 1'b1;
    end else begin
      r           = v[15:8];
      rd_msb_next = 1'b0;
      latch_held  = 1'b0;
    end
  endtask

  task automatic clock_edge();
    if (!counting) return;
    if (load_next) begin
      count_val = reload_val;
      load_next = 1'b0;
      return;
    end
    if (rate_mode(mode_sel)) begin
      if (count_val == count_t'(1)) begin
        count_val = reload_val;
        out_pin   = 1'b1;
      end else begin
        count_val = count_val - 1'b1;
        if (count_val == count_t'(1)) out_pin = 1'b0;
      end
    end else begin
      count_val = count_val - 1'b1;
      if (count_val == '0) out_pin = 1'b1;
    end
  endtask

  task automatic predict_timer(input in_item_t it, output out_item_t res);
    logic was_high;
    res = '0;
    case (it.command)
      CMD_WRITE: begin
        if (it.port == PORT_CTRL) control_word(it.write_data);
        else count_byte(it.write_data);
      end
      CMD_READ: begin
        if (it.port == PORT_DATA) read_byte(res.read_data);
      end
      CMD_TICK: begin
        was_high = out_pin;
        clock_edge();
        res.irq = !was_high && out_pin;
      end
      default: ;
    endcase
    res.out_level = out_pin;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      clear_timer();
      timer_results_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        predict_timer(in_item, want);
        timer_results_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = out_item;
        if (timer_results_q.size() == 0) begin
          $display("%0t: unexpected item rd=%02h irq=%b lvl=%b", $time,
                   got.read_data, got.irq, got.out_level);
          fail_count++;
        end else begin
          want = timer_results_q.pop_front();
          if (got.read_data !== want.read_data) begin
            $display("%0t: read_data expected %02h got %02h", $time,
                     want.read_data, got.read_data);
            fail_count++;
          end
          if (got.irq !== want.irq) begin
            $display("%0t: irq expected %b got %b", $time, want.irq, got.irq);
            fail_count++;
          end
          if (got.out_level !== want.out_level) begin
            $display("%0t: out_level expected %b got %b", $time,
                     want.out_level, got.out_level);
            fail_count++;
          end
        end
      end
    end
    results_due <= timer_results_q.size();
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
  import itc_pkg::*;

  // no package name for the unused command code
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 500;   // per phase

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  int fail_count;
  int results_due;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;

  always #2 clk = ~clk;

  interval_timer_counter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  itc_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .fail_count (fail_count),
    .results_due(results_due)
  );

  // Receiver back-pressure, redrawn every cycle at the falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[interval_timer_counter] ERROR");
      $finish;
    end
  end

  // Offer one item; valid stays high until the handshake. Random idle cycles
  // go in front of the item. Returns on the falling edge after acceptance,
  // leaving valid up so back-to-back items need no toggle.
  task automatic put_item(input logic [1:0] cmd, input logic port, input logic [7:0] data);
    in_item_t it;
    it.command    = cmd;
    it.port       = port;
    it.write_data = data;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] mode_word(input logic [2:0] mode, input logic bcd);
    return {SEL_COUNTER0, ACCESS_LSB_MSB, mode, bcd};
  endfunction

  // control word, then LSB and MSB of the count
  task automatic program_count(input logic [2:0] mode, input logic [15:0] count);
    put_item(CMD_WRITE, PORT_CTRL, mode_word(mode, 1'($urandom_range(1))));
    put_item(CMD_WRITE, PORT_DATA, count[7:0]);
    put_item(CMD_WRITE, PORT_DATA, count[15:8]);
  endtask

  task automatic tick_run(input int n);
    repeat (n) put_item(CMD_TICK, 1'($urandom_range(1)), 8'($urandom));
  endtask

  task automatic directed_items();
    // data before any control word: LSB/MSB, mode 0
    put_item(CMD_WRITE, PORT_DATA, 8'h03);
    put_item(CMD_WRITE, PORT_DATA, 8'h00);
    tick_run(5);                       // load, count to terminal, keep wrapping
    // mode 2 with count 1: output never falls
    put_item(CMD_WRITE, PORT_CTRL, mode_word(3'd2, 1'b0));
    put_item(CMD_WRITE, PORT_DATA, 8'h01);
    put_item(CMD_WRITE, PORT_DATA, 8'h00);
    tick_run(3);
    // latch, second latch ignored, byte reads, read of control port
    put_item(CMD_WRITE, PORT_CTRL, 8'h00);
    put_item(CMD_WRITE, PORT_CTRL, 8'h0F);
    put_item(CMD_READ, PORT_DATA, 8'h00);
    put_item(CMD_READ, PORT_DATA, 8'hFF);
    put_item(CMD_READ, PORT_CTRL, 8'hAA);
    // unused command, other counters, one-byte access modes
    put_item(CMD_NONE, PORT_CTRL, 8'hFF);
    put_item(CMD_WRITE, PORT_CTRL, 8'hF4);
    put_item(CMD_WRITE, PORT_CTRL, 8'h10);
    put_item(CMD_WRITE, PORT_CTRL, 8'h20);
    // mode 7 with BCD bit set, count 0 (full range)
    put_item(CMD_WRITE, PORT_CTRL, 8'h3F);
    put_item(CMD_WRITE, PORT_DATA, 8'h00);
    put_item(CMD_WRITE, PORT_DATA, 8'h00);
    tick_run(2);
    put_item(CMD_READ, PORT_DATA, 8'h00);
    put_item(CMD_READ, PORT_DATA, 8'h00);
    // mode 7 rewrite: LSB halts counting, MSB restarts with output low
    put_item(CMD_WRITE, PORT_DATA, 8'hFF);
    tick_run(1);
    put_item(CMD_WRITE, PORT_DATA, 8'hFF);
    tick_run(1);
  endtask

  // Mostly well-formed programming sequences with ticks, latches and reads
  // mixed in; the rest is raw noise and half-written counts.
  task automatic random_items(input int n);
    int sent;
    int len;
    int pick;
    logic [2:0] mode;
    logic [15:0] count;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 75) begin
        mode = ($urandom_range(99) < 45) ? 3'd2 : 3'($urandom_range(7));
        pick = $urandom_range(99);
        if (pick < 65) count = 16'($urandom_range(12, 1));
        else if (pick < 75) count = 16'($urandom_range(2));
        else if (pick < 85) count = 16'($urandom_range(255));
        else count = 16'($urandom);
        if ($urandom_range(99) < 10) begin
          // broken: MSB never arrives
          put_item(CMD_WRITE, PORT_CTRL, mode_word(mode, 1'($urandom_range(1))));
          put_item(CMD_WRITE, PORT_DATA, count[7:0]);
          sent += 2;
        end else begin
          program_count(mode, count);
          sent += 3;
        end
        len = $urandom_range(30, 1);
        repeat (len) begin
          pick = $urandom_range(99);
          if (pick < 70) begin
            put_item(CMD_TICK, 1'($urandom_range(1)), 8'($urandom));
          end else if (pick < 82) begin
            put_item(CMD_READ, PORT_DATA, 8'($urandom));
          end else if (pick < 90) begin
            // latch: upper four bits zero, the rest don't care
            put_item(CMD_WRITE, PORT_CTRL, {4'h0, 4'($urandom)});
          end else if (pick < 96) begin
            // new count mid-run
            put_item(CMD_WRITE, PORT_DATA, 8'($urandom_range(12, 1)));
            put_item(CMD_WRITE, PORT_DATA, ($urandom_range(3) == 0) ? 8'($urandom) : 8'h00);
            sent++;
          end else begin
            put_item(CMD_WRITE, PORT_DATA, 8'($urandom));
          end
          sent++;
        end
      end else begin
        repeat ($urandom_range(4, 1)) begin
          put_item(2'($urandom), 1'($urandom), 8'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin
    int settle;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // phase 1: light sender gaps, heavy receiver stalls
    send_idle_pct  = 10;
    recv_stall_pct = 50;
    directed_items();
    random_items(RANDOM_ITEMS);

    // phase 2: the other way round
    send_idle_pct  = 50;
    recv_stall_pct = 10;
    random_items(RANDOM_ITEMS);

    // phase 3: full rate both sides
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_items(RANDOM_ITEMS);

    in_valid <= 1'b0;
    // drain: the watchdog covers a result that never shows up
    while (results_due != 0) @(negedge clk);
    settle = 10;                       // well past the two-stage pipeline
    repeat (settle) @(negedge clk);

    if (fail_count == 0) begin
      $display("[interval_timer_counter] OK");
    end else begin
      $display("[interval_timer_counter] ERROR");
    end
    $finish;
  end

endmodule
